// ===== hw/rtl/vaef_pkg.sv =====
// Package for the vertex axis extremes finder.
// Holds field widths, function and status codes and the scan tag type.
// No dependencies; imported by the interfaces and every module of the block.
package vaef_pkg;

  localparam int COORD_W   = 16;  // vertex coordinate and axis component width
  localparam int PROD_W    = 2 * COORD_W;
  localparam int PROJ_W    = 35;  // exact projection, sum of three products
  localparam int IDX_OUT_W = 6;   // width of the index fields of a result

  // Function codes of an input transaction
  localparam logic [1:0] FUNC_ADD   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  // Status codes of a result transaction
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_FULL   = 2'd1;
  localparam logic [1:0] STAT_ANSWER = 2'd2;

  // Control tag that travels alongside a vertex through the scan pipeline
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } vaef_tag_t;

endpackage

// ===== hw/rtl/vaef_if.sv =====
// Valid/ready channel interfaces of the vertex axis extremes finder.
// vaef_in_if carries input transactions, vaef_out_if result transactions.
// Depends on vaef_pkg for field widths.
interface vaef_in_if
  import vaef_pkg::*;
();
  logic                      valid;
  logic                      ready;
  logic [1:0]                func;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;
  logic signed [COORD_W-1:0] coord_z;
  logic signed [COORD_W-1:0] axis_x;
  logic signed [COORD_W-1:0] axis_y;
  logic signed [COORD_W-1:0] axis_z;

  modport source (output valid, func, coord_x, coord_y, coord_z, axis_x, axis_y, axis_z,
                  input ready);
  modport sink   (input valid, func, coord_x, coord_y, coord_z, axis_x, axis_y, axis_z,
                  output ready);
endinterface

interface vaef_out_if
  import vaef_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           status;
  logic [IDX_OUT_W-1:0] min_vertex;
  logic [IDX_OUT_W-1:0] max_vertex;

  modport source (output valid, status, min_vertex, max_vertex, input ready);
  modport sink   (input valid, status, min_vertex, max_vertex, output ready);
endinterface

// ===== hw/rtl/vertex_axis_extremes_finder_core.sv =====
// Vertex axis extremes finder: keeps up to MAX_VERTS vertices and, on a query,
// returns the first vertex of greatest and the last of least projection on an axis.
// An add, a clear or an unused function code passes through the result stage to the
// output register. A query on a non-empty table first scans the stored vertices: the
// vertex memory has one read port and the single shared dot product unit takes one
// vertex a cycle, behind a registered read, a product stage and a sum stage. One
// transaction is worked on at a time; a finished result sits in an output register,
// so the next transaction is accepted while it waits.
// Depends on vaef_pkg, vaef_if and vaef_dot_unit.
module vertex_axis_extremes_finder_core
  import vaef_pkg::*;
#(
  parameter int MAX_VERTS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  vaef_in_if.sink    in_if,
  vaef_out_if.source out_if
);

  localparam int IW = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int CW = $clog2(MAX_VERTS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  // Control state
  state_t          state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            issue_r, issue_nxt;
  logic [CW-1:0]   issue_cnt_r, issue_cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  vaef_tag_t       tag_rd_r;

  // Payload state
  logic signed [COORD_W-1:0] axis_x_r, axis_x_nxt;
  logic signed [COORD_W-1:0] axis_y_r, axis_y_nxt;
  logic signed [COORD_W-1:0] axis_z_r, axis_z_nxt;
  logic signed [PROJ_W-1:0]  best_max_r, best_max_nxt;
  logic signed [PROJ_W-1:0]  best_min_r, best_min_nxt;
  logic [IW-1:0]             max_idx_r, max_idx_nxt;
  logic [IW-1:0]             min_idx_r, min_idx_nxt;
  logic [1:0]                res_status_r, res_status_nxt;
  logic [IDX_OUT_W-1:0]      res_min_r, res_min_nxt;
  logic [IDX_OUT_W-1:0]      res_max_r, res_max_nxt;
  logic [1:0]                out_status_r, out_status_nxt;
  logic [IDX_OUT_W-1:0]      out_min_r, out_min_nxt;
  logic [IDX_OUT_W-1:0]      out_max_r, out_max_nxt;
  logic [IW-1:0]             idx_rd_r;

  // Vertex memory
  logic [3*COORD_W-1:0] vmem [MAX_VERTS];
  logic [3*COORD_W-1:0] rd_data_r;
  logic                 wr_en;

  // Scan pipeline outputs
  logic signed [PROJ_W-1:0] proj;
  vaef_tag_t                tag_dot;
  logic [IW-1:0]            idx_dot;

  logic          in_acc;
  logic          out_free;
  logic          has_room;
  logic [CW-1:0] last_idx;
  logic          take_max, take_min;

  // Truncate or extend a table index to the result field width
  function automatic logic [IDX_OUT_W-1:0] to_field(input logic [IW-1:0] idx);
    logic [IW+IDX_OUT_W-1:0] ext;
    ext = {{IDX_OUT_W{1'b0}}, idx};
    return ext[IDX_OUT_W-1:0];
  endfunction

  assign in_if.ready = (state_r == S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign has_room    = (count_r < CW'(MAX_VERTS));
  assign last_idx    = count_r - 1'b1;
  assign wr_en       = in_acc && (in_if.func == FUNC_ADD) && has_room;

  assign take_max = tag_dot.first || (proj > best_max_r);
  assign take_min = tag_dot.first || (proj <= best_min_r);

  // Sequencer and result selection
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    issue_nxt      = issue_r;
    issue_cnt_nxt  = issue_cnt_r;
    out_valid_nxt  = out_valid_r;
    axis_x_nxt     = axis_x_r;
    axis_y_nxt     = axis_y_r;
    axis_z_nxt     = axis_z_r;
    best_max_nxt   = best_max_r;
    best_min_nxt   = best_min_r;
    max_idx_nxt    = max_idx_r;
    min_idx_nxt    = min_idx_r;
    res_status_nxt = res_status_r;
    res_min_nxt    = res_min_r;
    res_max_nxt    = res_max_r;
    out_status_nxt = out_status_r;
    out_min_nxt    = out_min_r;
    out_max_nxt    = out_max_r;

    if (out_valid_r && out_if.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          res_status_nxt = STAT_OK;
          res_min_nxt    = '0;
          res_max_nxt    = '0;
          state_nxt      = S_EMIT;
          unique case (in_if.func)
            FUNC_ADD: begin
              if (has_room) begin
                count_nxt = count_r + 1'b1;
              end else begin
                res_status_nxt = STAT_FULL;
              end
            end
            FUNC_QUERY: begin
              axis_x_nxt     = in_if.axis_x;
              axis_y_nxt     = in_if.axis_y;
              axis_z_nxt     = in_if.axis_z;
              res_status_nxt = STAT_ANSWER;
              if (count_r != '0) begin
                issue_nxt     = 1'b1;
                issue_cnt_nxt = '0;
                state_nxt     = S_SCAN;
              end
            end
            FUNC_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        // Issue one memory read per cycle
        if (issue_r) begin
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          if (issue_cnt_r == last_idx) begin
            issue_nxt = 1'b0;
          end
        end
        // Running extremes: max strictly greater, min less-or-equal
        if (tag_dot.valid) begin
          if (take_max) begin
            best_max_nxt = proj;
            max_idx_nxt  = idx_dot;
          end
          if (take_min) begin
            best_min_nxt = proj;
            min_idx_nxt  = idx_dot;
          end
          if (tag_dot.last) begin
            res_max_nxt = to_field(max_idx_nxt);
            res_min_nxt = to_field(min_idx_nxt);
            state_nxt   = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_status_nxt = res_status_r;
          out_min_nxt    = res_min_r;
          out_max_nxt    = res_max_r;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      issue_r     <= 1'b0;
      issue_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_r     <= issue_nxt;
      issue_cnt_r <= issue_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    axis_x_r     <= axis_x_nxt;
    axis_y_r     <= axis_y_nxt;
    axis_z_r     <= axis_z_nxt;
    best_max_r   <= best_max_nxt;
    best_min_r   <= best_min_nxt;
    max_idx_r    <= max_idx_nxt;
    min_idx_r    <= min_idx_nxt;
    res_status_r <= res_status_nxt;
    res_min_r    <= res_min_nxt;
    res_max_r    <= res_max_nxt;
    out_status_r <= out_status_nxt;
    out_min_r    <= out_min_nxt;
    out_max_r    <= out_max_nxt;
  end

  // Vertex memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      vmem[count_r[IW-1:0]] <= {in_if.coord_x, in_if.coord_y, in_if.coord_z};
    end
    rd_data_r <= vmem[issue_cnt_r[IW-1:0]];
  end

  // Tag for the vertex being read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_rd_r <= '0;
    end else begin
      tag_rd_r.valid <= issue_r;
      tag_rd_r.first <= (issue_cnt_r == '0);
      tag_rd_r.last  <= (issue_cnt_r == last_idx);
    end
    idx_rd_r <= issue_cnt_r[IW-1:0];
  end

  vaef_dot_unit #(
    .IDX_W (IW)
  ) u_dot (
    .clk     (clk),
    .rst_n   (rst_n),
    .axis_x  (axis_x_r),
    .axis_y  (axis_y_r),
    .axis_z  (axis_z_r),
    .vtx     (rd_data_r),
    .tag_in  (tag_rd_r),
    .idx_in  (idx_rd_r),
    .proj    (proj),
    .tag_out (tag_dot),
    .idx_out (idx_dot)
  );

  assign out_if.valid      = out_valid_r;
  assign out_if.status     = out_status_r;
  assign out_if.min_vertex = out_min_r;
  assign out_if.max_vertex = out_max_r;

  // The table never holds more vertices than it has room for
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTS))
    else $error("vertex count exceeds table depth");

  // No scan work is in flight while a new transaction can be accepted
  a_idle_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.ready |-> (!issue_r && !tag_rd_r.valid && !tag_dot.valid))
    else $error("scan pipeline busy while accepting input");

  // A query on an empty table goes straight to the result stage
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_if.func == FUNC_QUERY && count_r == '0) |=> (state_r == S_EMIT))
    else $error("empty-table query did not complete at once");

  // The table is unchanged across a scan
  a_scan_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> $stable(count_r))
    else $error("vertex count changed during a scan");

endmodule

// ===== hw/rtl/vaef_dot_unit.sv =====
// Shared two-stage dot product unit of the vertex axis extremes finder.
// Stage one forms three 16x16 signed products, stage two their exact sum.
// Depends on vaef_pkg for widths and the scan tag type.
module vaef_dot_unit
  import vaef_pkg::*;
#(
  parameter int IDX_W = 6
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [COORD_W-1:0] axis_x,
  input  logic signed [COORD_W-1:0] axis_y,
  input  logic signed [COORD_W-1:0] axis_z,
  input  logic [3*COORD_W-1:0]      vtx,
  input  vaef_tag_t                 tag_in,
  input  logic [IDX_W-1:0]          idx_in,
  output logic signed [PROJ_W-1:0]  proj,
  output vaef_tag_t                 tag_out,
  output logic [IDX_W-1:0]          idx_out
);

  logic signed [COORD_W-1:0] vx, vy, vz;
  logic signed [PROD_W-1:0]  px_r, py_r, pz_r;
  vaef_tag_t                 tag_p_r, tag_s_r;
  logic [IDX_W-1:0]          idx_p_r, idx_s_r;
  logic signed [PROJ_W-1:0]  proj_r;

  // Unpack the stored vertex: x in the top field, z in the bottom one
  assign vx = $signed(vtx[3*COORD_W-1:2*COORD_W]);
  assign vy = $signed(vtx[2*COORD_W-1:COORD_W]);
  assign vz = $signed(vtx[COORD_W-1:0]);

  // Tag pipeline, valid cleared on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag_p_r <= '0;
      tag_s_r <= '0;
    end else begin
      tag_p_r <= tag_in;
      tag_s_r <= tag_p_r;
    end
    idx_p_r <= idx_in;
    idx_s_r <= idx_p_r;
  end

  // Product stage and sum stage
  always_ff @(posedge clk) begin
    px_r   <= axis_x * vx;
    py_r   <= axis_y * vy;
    pz_r   <= axis_z * vz;
    proj_r <= PROJ_W'(px_r) + PROJ_W'(py_r) + PROJ_W'(pz_r);
  end

  assign proj    = proj_r;
  assign tag_out = tag_s_r;
  assign idx_out = idx_s_r;

endmodule
